// ===== rtl/brp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bencode response parser package
// Sizes, status codes and item types shared by the parser modules.
// ----------------------------------------------------------------------------
package brp_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int LENGTH_BITS  = 16;
	localparam int POS_BITS     = $clog2(BUFFER_DEPTH + 1);

	localparam logic [1:0] ST_PARTIAL = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_ERROR   = 2'd2;
	localparam logic [1:0] ST_RESET   = 2'd3;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_INT   = 8'h69;
	localparam logic [7:0] CH_END   = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic       req_type;
		logic [7:0] in_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] byte_pos;
		logic [7:0] byte_echo;
	} rsp_t;

endpackage

// ===== rtl/brp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser request channel
// Valid and ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface brp_req_if;

	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] in_byte;

	modport source (output valid, output req_type, output in_byte, input ready);
	modport sink (input valid, input req_type, input in_byte, output ready);

endinterface

// ===== rtl/brp_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser response channel
// Valid and ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface brp_rsp_if;

	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] byte_pos;
	logic [7:0] byte_echo;

	modport source (output valid, output status, output byte_pos, output byte_echo,
		input ready);
	modport sink (input valid, input status, input byte_pos, input byte_echo,
		output ready);

endinterface

// ===== rtl/brp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser step
// Holds the parse phase, length countdown and byte position, and works out
// the result of one item from them.
// ----------------------------------------------------------------------------
module brp_step
	import brp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  req_t item,
	output rsp_t result
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_INT,
		PH_LEN,
		PH_STR,
		PH_READY
	} phase_t;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	phase_t                phase_q, phase_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [POS_BITS-1:0]    pos_q, pos_d;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [LENGTH_BITS+4:0] grown;
	logic [LENGTH_BITS-1:0] len_dec;

	assign is_digit = (item.in_byte >= CH_ZERO) && (item.in_byte <= CH_NINE);
	assign digit    = item.in_byte[3:0];
	assign grown    = ((LENGTH_BITS + 5)'(len_q) << 3) + ((LENGTH_BITS + 5)'(len_q) << 1)
		+ (LENGTH_BITS + 5)'(digit);
	assign len_dec  = (len_q != '0) ? len_q - 1'b1 : len_q;

	always_comb begin
		phase_d          = phase_q;
		len_d            = len_q;
		pos_d            = pos_q;
		result.status    = ST_PARTIAL;
		result.byte_pos  = 8'(pos_q);
		result.byte_echo = item.in_byte;
		if (item.req_type) begin
			result.status    = ST_RESET;
			result.byte_pos  = 8'd0;
			result.byte_echo = 8'd0;
		end else if (pos_q >= POS_BITS'(BUFFER_DEPTH)) begin
			result.status = ST_ERROR;
		end else begin
			pos_d = pos_q + 1'b1;
			case (phase_q)
				PH_IDLE: begin
					if (item.in_byte == CH_PLUS || item.in_byte == CH_MINUS) begin
						phase_d = PH_HEADER;
					end else begin
						result.status = ST_ERROR;
					end
				end
				PH_HEADER: begin
					if (item.in_byte == CH_INT) begin
						phase_d = PH_INT;
					end else if (is_digit) begin
						phase_d = PH_LEN;
						len_d   = LENGTH_BITS'(digit);
					end else begin
						result.status = ST_ERROR;
					end
				end
				PH_INT: begin
					if (item.in_byte == CH_END) begin
						phase_d       = PH_READY;
						result.status = ST_READY;
					end else if (!is_digit) begin
						result.status = ST_ERROR;
					end
				end
				PH_LEN: begin
					if (item.in_byte == CH_COLON) begin
						if (len_q == '0) begin
							phase_d       = PH_READY;
							result.status = ST_READY;
						end else begin
							phase_d = PH_STR;
						end
					end else if (is_digit) begin
						len_d = (|grown[LENGTH_BITS+4:LENGTH_BITS]) ? LEN_MAX
							: grown[LENGTH_BITS-1:0];
					end else begin
						result.status = ST_ERROR;
					end
				end
				PH_STR: begin
					len_d = len_dec;
					if (len_dec == '0) begin
						phase_d       = PH_READY;
						result.status = ST_READY;
					end
				end
				default: begin
					result.status = ST_ERROR;
				end
			endcase
		end
		if (item.req_type || result.status == ST_ERROR) begin
			phase_d = PH_IDLE;
			len_d   = '0;
			pos_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q   <= '0;
			pos_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
		end
	end

endmodule

// ===== rtl/bencode_response_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bencode response parser core
// Checks a response one byte per item and echoes each byte with its buffer
// position and a partial, ready or error status; a reset item gets a reset status.
//
//   Channel  Role    Payload
//   req      sink    req_type, in_byte
//   rsp      source  status, byte_pos, byte_echo
//
// One item per cycle is sustained while the receiver takes results; each item
// passes from acceptance to its result through the input and result registers.
// The parse state is updated as an item moves from the input register into
// the result register, so consecutive items follow without a gap.
// A stalled result holds in the result register while the input register
// still takes one more item. Reset returns the parser to idle at once.
// ----------------------------------------------------------------------------
module bencode_response_parser_core
	import brp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	brp_req_if.sink    req,
	brp_rsp_if.source  rsp
);

	logic valid_s1;
	req_t item_s1;
	logic valid_s2;
	rsp_t result_s2;
	rsp_t result;
	logic advance;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	brp_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type <= req.req_type;
			item_s1.in_byte  <= req.in_byte;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.status    = result_s2.status;
	assign rsp.byte_pos  = result_s2.byte_pos;
	assign rsp.byte_echo = result_s2.byte_echo;

endmodule

// ===== verif/bencode_response_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bencode response parser checker
// Watches the request and result channels of the parser core, keeps its own
// copy of the parse state to work out the result of every accepted item, and
// compares each accepted result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module bencode_response_parser_checker
	import brp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	brp_req_if   req,
	brp_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding
);

	typedef enum logic [2:0] {
		P_IDLE,
		P_HEADER,
		P_INT,
		P_LEN,
		P_STR,
		P_READY
	} parse_phase_t;

	localparam logic [LENGTH_BITS-1:0] LEN_SAT = '1;

	parse_phase_t           phase;
	logic [LENGTH_BITS-1:0] len_left;
	logic [POS_BITS-1:0]    next_pos;
	rsp_t                   due_q[$];

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic void clear_parse();
		phase    = P_IDLE;
		len_left = '0;
		next_pos = '0;
	endfunction

	function automatic logic [1:0] parse_char(input logic [7:0] c);
		logic [31:0] grown;
		if (next_pos >= BUFFER_DEPTH)
			return ST_ERROR;
		next_pos = next_pos + 1'b1;
		case (phase)
			P_IDLE: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					phase = P_HEADER;
					return ST_PARTIAL;
				end
			end
			P_HEADER: begin
				if (c == CH_INT) begin
					phase = P_INT;
					return ST_PARTIAL;
				end
				if (is_digit(c)) begin
					phase    = P_LEN;
					len_left = LENGTH_BITS'(c - CH_ZERO);
					return ST_PARTIAL;
				end
			end
			P_INT: begin
				if (c == CH_END) begin
					phase = P_READY;
					return ST_READY;
				end
				if (is_digit(c))
					return ST_PARTIAL;
			end
			P_LEN: begin
				if (c == CH_COLON) begin
					if (len_left == '0) begin
						phase = P_READY;
						return ST_READY;
					end
					phase = P_STR;
					return ST_PARTIAL;
				end
				if (is_digit(c)) begin
					grown    = 32'(len_left) * 32'd10 + 32'(c - CH_ZERO);
					len_left = (grown > 32'(LEN_SAT)) ? LEN_SAT : grown[LENGTH_BITS-1:0];
					return ST_PARTIAL;
				end
			end
			P_STR: begin
				if (len_left != '0)
					len_left = len_left - 1'b1;
				if (len_left == '0) begin
					phase = P_READY;
					return ST_READY;
				end
				return ST_PARTIAL;
			end
			default: begin
			end
		endcase
		return ST_ERROR;
	endfunction

	function automatic rsp_t predict_response(input req_t item);
		rsp_t r;
		if (item.req_type) begin
			clear_parse();
			r.status    = ST_RESET;
			r.byte_pos  = '0;
			r.byte_echo = '0;
			return r;
		end
		r.byte_pos  = next_pos[7:0];
		r.byte_echo = item.in_byte;
		r.status    = parse_char(item.in_byte);
		if (r.status == ST_ERROR)
			clear_parse();
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int   bad;
		rsp_t want;
		req_t item;
		if (!arst_n) begin
			clear_parse();
			due_q.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (rsp.valid && rsp.ready) begin
				if (due_q.size() == 0) begin
					$error("result with no item outstanding: status %0d, byte_pos %0d, byte_echo %0d",
						rsp.status, rsp.byte_pos, rsp.byte_echo);
					bad++;
				end else begin
					want = due_q.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						bad++;
					end
					if (rsp.byte_pos !== want.byte_pos) begin
						$error("byte_pos: expected %0d, actual %0d", want.byte_pos, rsp.byte_pos);
						bad++;
					end
					if (rsp.byte_echo !== want.byte_echo) begin
						$error("byte_echo: expected %0d, actual %0d", want.byte_echo,
							rsp.byte_echo);
						bad++;
					end
				end
			end
			if (req.valid && req.ready) begin
				item.req_type = req.req_type;
				item.in_byte  = req.in_byte;
				due_q.push_back(predict_response(item));
			end
			mismatches  <= mismatches + bad;
			outstanding <= due_q.size();
		end
	end

endmodule

// ===== verif/bencode_response_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bencode response parser core testbench
// Sends short directed responses and then random well-formed, truncated and
// corrupted responses in bursts, with a receiver that stalls on changing
// patterns. The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module bencode_response_parser_core_tb;
	import brp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEM_TARGET    = 1800;
	localparam int DRAIN_EVERY    = 450;

	typedef enum int {
		RDY_ALWAYS,
		RDY_MOSTLY,
		RDY_RARELY,
		RDY_PERIODIC
	} ready_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	int          mismatches;
	int          outstanding;
	int          stall_cycles = 0;
	int          sent = 0;
	int          burst_left = 0;
	int          mode_left = 0;
	ready_mode_t ready_mode = RDY_ALWAYS;

	brp_req_if req ();
	brp_rsp_if rsp ();

	bencode_response_parser_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	bencode_response_parser_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= ready_mode_t'($urandom_range(0, 3));
				mode_left  <= $urandom_range(16, 160);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				RDY_ALWAYS:   rsp.ready <= 1'b1;
				RDY_MOSTLY:   rsp.ready <= ($urandom_range(0, 3) != 0);
				RDY_RARELY:   rsp.ready <= ($urandom_range(0, 3) == 0);
				default:      rsp.ready <= ((mode_left & 4) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic req_t byte_item(input logic [7:0] b);
		return '{1'b0, b};
	endfunction

	task automatic send_item(input logic rt, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		req.valid    <= 1'b1;
		req.req_type <= rt;
		req.in_byte  <= b;
		do @(posedge clk); while (!req.ready);
		burst_left--;
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(1'b0, s[i]);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		req_t        msg[$];
		logic [7:0]  digits[$];
		logic [7:0]  hdr;
		int          kind;
		int          sel;
		int          n;
		int          cut;
		int          next_drain;
		int unsigned len_val;
		int unsigned v;

		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.req_type <= 1'b0;
		req.in_byte  <= 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Empty integer, then a byte after ready.
		send_text("+ie");
		send_text("x");
		send_text("-i09e");
		send_item(1'b1, 8'hFF);
		// Zero length string.
		send_text("+0:");
		send_item(1'b1, 8'h00);
		send_text("+2:");
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_text("+i:");
		send_text("+1i");
		drain();

		next_drain = sent + DRAIN_EVERY;
		while (sent < ITEM_TARGET) begin
			msg.delete();
			kind = $urandom_range(0, 99);
			hdr  = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
			if (kind < 75) begin
				msg.push_back(byte_item(hdr));
				if (kind < 35) begin
					msg.push_back(byte_item(CH_INT));
					n = $urandom_range(0, 8);
					repeat (n) msg.push_back(byte_item(8'(CH_ZERO + $urandom_range(0, 9))));
					msg.push_back(byte_item(CH_END));
				end else begin
					sel = $urandom_range(0, 99);
					if (sel < 80)
						len_val = $urandom_range(0, 20);
					else if (sel < 95)
						len_val = $urandom_range(21, 99);
					else if (sel < 98)
						len_val = $urandom_range(200, 300);
					else
						len_val = $urandom;
					digits.delete();
					v = len_val;
					do begin
						digits.push_front(CH_ZERO + 8'(v % 10));
						v = v / 10;
					end while (v != 0);
					if ($urandom_range(0, 9) == 0)
						digits.push_front(CH_ZERO);
					foreach (digits[i])
						msg.push_back(byte_item(digits[i]));
					msg.push_back(byte_item(CH_COLON));
					n = (len_val > 300) ? 300 : int'(len_val);
					repeat (n) msg.push_back(byte_item(8'($urandom_range(0, 255))));
				end
				if ($urandom_range(0, 9) == 0) begin
					cut = $urandom_range(1, msg.size());
					msg = msg[0:cut-1];
				end
				if ($urandom_range(0, 9) < 7)
					msg.push_back('{1'b1, 8'($urandom_range(0, 255))});
				else
					msg.push_back(byte_item(8'($urandom_range(0, 255))));
			end else if (kind < 88) begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					case ($urandom_range(0, 7))
						0:       msg.push_back(byte_item(CH_PLUS));
						1:       msg.push_back(byte_item(CH_MINUS));
						2:       msg.push_back(byte_item(CH_INT));
						3:       msg.push_back(byte_item(CH_END));
						4:       msg.push_back(byte_item(CH_COLON));
						5, 6:    msg.push_back(byte_item(8'(CH_ZERO + $urandom_range(0, 9))));
						default: msg.push_back(byte_item(8'($urandom_range(0, 255))));
					endcase
				end
				msg.push_back('{1'b1, 8'($urandom_range(0, 255))});
			end else begin
				msg.push_back('{1'b1, 8'($urandom_range(0, 255))});
			end
			foreach (msg[i])
				send_item(msg[i].req_type, msg[i].in_byte);
			if (sent >= next_drain) begin
				drain();
				next_drain = sent + DRAIN_EVERY;
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
